FILE: hw/rtl/cbs_pkg.sv
// Shared types and constants of the cubic B-spline sampler.
package cbs_pkg;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 25;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = 58;
   localparam int ACC_W   = 58;

   // weight products and weights
   localparam int PR_W      = 20;
   localparam int NUM_PRODS = 9;
   localparam int WGT_W     = 25;
   localparam int CNT_W     = 7;

   // divide / square root unit
   localparam int DVD_W     = 58;
   localparam int DVS_W     = 26;
   localparam int REM_W     = 28;
   localparam int ROOT_W    = 25;
   localparam int SQ_IN_W   = 50;
   localparam int STEP_W    = 6;
   localparam int DIV_STEPS = 58;
   localparam int SQ_STEPS  = 25;

   // unit vector format and normalization window [2^23, 2^24)
   localparam int UNIT_W    = 16;
   localparam int UNIT_FRAC = 14;
   localparam int NRM_HI    = 24;
   localparam int NRM_LO    = 23;

   localparam logic [CNT_W-1:0] SCOUNT_RESET = 7'd8;

   typedef enum logic [0:0] {
      UNIT_DIV  = 1'b0,
      UNIT_SQRT = 1'b1
   } unit_op_type;

   typedef struct packed {
      logic        start;
      unit_op_type op;
   } unit_req_type;

   typedef struct packed {
      logic done;
   } unit_sts_type;

   typedef enum logic [16:0] {
      ST_IDLE       = 17'h00001,
      ST_PREP_MUL   = 17'h00002,
      ST_PREP_ACC   = 17'h00004,
      ST_WGT        = 17'h00008,
      ST_MAC_MUL    = 17'h00010,
      ST_MAC_ACC    = 17'h00020,
      ST_POS_START  = 17'h00040,
      ST_POS_WAIT   = 17'h00080,
      ST_VEC_LOAD   = 17'h00100,
      ST_VEC_NORM   = 17'h00200,
      ST_SQ_MUL     = 17'h00400,
      ST_SQ_ACC     = 17'h00800,
      ST_SQRT_START = 17'h01000,
      ST_SQRT_WAIT  = 17'h02000,
      ST_UDIV_START = 17'h04000,
      ST_UDIV_WAIT  = 17'h08000,
      ST_EMIT       = 17'h10000
   } state_type;

endpackage

FILE: hw/rtl/cbs_divsqrt.sv
// Shared restoring divider and integer square root, one step per cycle.
module cbs_divsqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  cbs_pkg::unit_req_type          unit_req,
   input  logic [cbs_pkg::DVD_W-1:0]      operand_a,
   input  logic [cbs_pkg::DVS_W-1:0]      operand_b,
   output cbs_pkg::unit_sts_type          unit_sts,
   output logic [cbs_pkg::DVD_W-1:0]      result
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   cbs_pkg::unit_op_type          op_ff, op_in;
   logic [cbs_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [cbs_pkg::DVD_W-1:0]     shreg_ff, shreg_in;
   logic [cbs_pkg::REM_W-1:0]     rem_ff, rem_in;
   logic [cbs_pkg::ROOT_W-1:0]    root_ff, root_in;
   logic [cbs_pkg::DVS_W-1:0]     dvs_ff, dvs_in;

   logic [cbs_pkg::REM_W-1:0]     cand;
   logic [cbs_pkg::REM_W-1:0]     subtrahend;
   logic [cbs_pkg::REM_W:0]       diff;
   logic                          ge;

   // one compare-subtract serves both operations
   always_comb begin
      if (op_ff == cbs_pkg::UNIT_SQRT) begin
         cand       = {rem_ff[cbs_pkg::REM_W-3:0], shreg_ff[cbs_pkg::DVD_W-1 -: 2]};
         subtrahend = cbs_pkg::REM_W'({root_ff, 2'b01});
      end else begin
         cand       = {rem_ff[cbs_pkg::REM_W-2:0], shreg_ff[cbs_pkg::DVD_W-1]};
         subtrahend = cbs_pkg::REM_W'(dvs_ff);
      end
      diff = {1'b0, cand} - {1'b0, subtrahend};
      ge   = !diff[cbs_pkg::REM_W];
   end

   // step sequencing
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      dvs_in   = dvs_ff;
      if (unit_req.start) begin
         busy_in = 1'b1;
         op_in   = unit_req.op;
         rem_in  = '0;
         root_in = '0;
         dvs_in  = operand_b;
         if (unit_req.op == cbs_pkg::UNIT_SQRT) begin
            cnt_in   = cbs_pkg::STEP_W'(cbs_pkg::SQ_STEPS);
            shreg_in = {operand_a[cbs_pkg::SQ_IN_W-1:0],
                        (cbs_pkg::DVD_W-cbs_pkg::SQ_IN_W)'(0)};
         end else begin
            cnt_in   = cbs_pkg::STEP_W'(cbs_pkg::DIV_STEPS);
            shreg_in = operand_a;
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[cbs_pkg::REM_W-1:0] : cand;
         if (op_ff == cbs_pkg::UNIT_SQRT) begin
            shreg_in = {shreg_ff[cbs_pkg::DVD_W-3:0], 2'b00};
            root_in  = {root_ff[cbs_pkg::ROOT_W-2:0], ge};
         end else begin
            shreg_in = {shreg_ff[cbs_pkg::DVD_W-2:0], ge};
         end
         cnt_in = cnt_ff - cbs_pkg::STEP_W'(1);
         if (cnt_ff == cbs_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      dvs_ff   <= dvs_in;
   end

   assign unit_sts.done = done_ff;
   assign result = (op_ff == cbs_pkg::UNIT_SQRT) ? cbs_pkg::DVD_W'(root_ff) : shreg_ff;

endmodule

FILE: hw/rtl/cubic_bspline_sampler.sv
// Top level: uniform cubic B-spline sampler with a shared multiplier and divide/sqrt unit.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata: point x,y,z   tuser: start_curve
//  rsp      out  rsp_tvalid/rsp_tready  tdata: pos, tangent, curvature
//                                       tuser: degenerate    tlast: last_sample
//  csr      in   csr_wr_en              csr_wr_data: sample_count
//
//  A point that only fills the window is stored while idle. A point closing a segment
//  produces sample_count samples (clamped to 1..MAX_SAMPLES), one after another; the
//  serial divide/square-root unit (58 steps per divide, nine divides per sample, three
//  fewer per zero derivative) sets the pace.
//  Reset is synchronous and clears control; the point window holds no reset value.
//  req_tready is high only while idle; a finished sample waits in the output
//  register while the next one is computed, and a stalled rsp side stalls the sequencer.
module cubic_bspline_sampler #(
   parameter int COORD_WIDTH = 16,
   parameter int MAX_SAMPLES = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [cbs_pkg::CNT_W-1:0]   csr_wr_data,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // point_x, point_y, point_z
   input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // start_curve
   input  logic                        req_tuser,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z, curv_x, curv_y, curv_z
   output logic [((3*COORD_WIDTH+6*cbs_pkg::UNIT_W+7)/8)*8-1:0] rsp_tdata,
   // degenerate
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   localparam int CW    = COORD_WIDTH;
   localparam int OUT_W = ((3*COORD_WIDTH+6*cbs_pkg::UNIT_W+7)/8)*8;
   localparam logic [cbs_pkg::DVD_W-1:0] SAT_MAG  = cbs_pkg::DVD_W'(1) << (CW-1);
   localparam logic [cbs_pkg::DVD_W-1:0] SAT_POS  = SAT_MAG - cbs_pkg::DVD_W'(1);
   localparam logic [CW-1:0]             POS_MAX  = SAT_POS[CW-1:0];
   localparam logic [CW-1:0]             NEG_MIN  = SAT_MAG[CW-1:0];

   cbs_pkg::state_type state_ff, state_in;

   logic [cbs_pkg::CNT_W-1:0] scount_ff, scount_in;
   logic [1:0]                held_ff, held_in;
   logic signed [CW-1:0]      win_ff [3][3];
   logic signed [CW-1:0]      win_in [3][3];
   logic signed [CW-1:0]      cur_ff [3];
   logic signed [CW-1:0]      cur_in [3];
   logic [cbs_pkg::CNT_W-1:0] n_ff, n_in;
   logic [cbs_pkg::CNT_W-1:0] s_ff, s_in;
   logic [3:0]                pidx_ff, pidx_in;
   logic [cbs_pkg::PR_W-1:0]  pr_ff [cbs_pkg::NUM_PRODS];
   logic [cbs_pkg::PR_W-1:0]  pr_in [cbs_pkg::NUM_PRODS];
   logic signed [cbs_pkg::WGT_W-1:0] wt_ff [3][4];
   logic signed [cbs_pkg::WGT_W-1:0] wt_in [3][4];
   logic [1:0]                fi_ff, fi_in, ji_ff, ji_in, ii_ff, ii_in;
   logic signed [cbs_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [cbs_pkg::ACC_W-1:0]  acc_ff [3][3];
   logic signed [cbs_pkg::ACC_W-1:0]  acc_in [3][3];
   logic [1:0]                axis_ff, axis_in;
   logic                      fam_ff, fam_in;
   logic [cbs_pkg::DVD_W-1:0] mag_ff [3];
   logic [cbs_pkg::DVD_W-1:0] mag_in [3];
   logic                      neg_ff [3];
   logic                      neg_in [3];
   logic [cbs_pkg::PROD_W-1:0] sum_ff, sum_in;
   logic [cbs_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CW-1:0]             pos_ff [3];
   logic [CW-1:0]             pos_in [3];
   logic [cbs_pkg::UNIT_W-1:0] uvec_ff [2][3];
   logic [cbs_pkg::UNIT_W-1:0] uvec_in [2][3];
   logic                      deg_ff, deg_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [OUT_W-1:0]          rsp_tdata_ff, rsp_tdata_in;
   logic                      rsp_tuser_ff, rsp_tuser_in;
   logic                      rsp_tlast_ff, rsp_tlast_in;

   // shared multiplier operands
   logic signed [cbs_pkg::MUL_A_W-1:0] mult_a;
   logic signed [cbs_pkg::MUL_B_W-1:0] mult_b;

   // divide / sqrt unit
   cbs_pkg::unit_req_type      unit_req;
   cbs_pkg::unit_sts_type      unit_sts;
   logic [cbs_pkg::DVD_W-1:0]  unit_a;
   logic [cbs_pkg::DVS_W-1:0]  unit_b;
   logic [cbs_pkg::DVD_W-1:0]  unit_result;

   // helpers
   logic signed [CW-1:0]       pts [4][3];
   logic signed [CW-1:0]       in_pt [3];
   logic signed [cbs_pkg::WGT_W-1:0] q [cbs_pkg::NUM_PRODS];
   logic signed [cbs_pkg::WGT_W-1:0] s_w, n_w, u_w;
   logic [cbs_pkg::CNT_W-1:0]  u_val, n_clamp;
   logic [1:0]                 held_eff;
   logic [cbs_pkg::DVD_W-1:0]  nrm_max;
   logic                       out_free;
   logic                       is_last;
   logic signed [cbs_pkg::ACC_W-1:0] acc_sel;
   logic [cbs_pkg::DVD_W-1:0]  acc_abs;
   logic [cbs_pkg::PR_W+2:0]   n3x3, n3x6;

   // control points of the current segment
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) pts[i][j] = win_ff[i][j];
         pts[3][j] = cur_ff[j];
         in_pt[j]  = req_tdata[j*CW +: CW];
      end
   end

   assign u_val   = n_ff - s_ff;
   assign is_last = (s_ff == n_ff - cbs_pkg::CNT_W'(1));
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign held_eff = req_tuser ? 2'd0 : held_ff;
   assign n3x3 = (cbs_pkg::PR_W+3)'(pr_ff[1]) * 3;
   assign n3x6 = (cbs_pkg::PR_W+3)'(pr_ff[1]) * 6;

   always_comb begin
      if (scount_ff == '0)
         n_clamp = cbs_pkg::CNT_W'(1);
      else if (scount_ff > cbs_pkg::CNT_W'(MAX_SAMPLES))
         n_clamp = cbs_pkg::CNT_W'(MAX_SAMPLES);
      else
         n_clamp = scount_ff;
   end

   // weights from the registered products
   always_comb begin
      for (int k = 0; k < cbs_pkg::NUM_PRODS; k++) q[k] = cbs_pkg::WGT_W'(pr_ff[k]);
      s_w = cbs_pkg::WGT_W'(s_ff);
      n_w = cbs_pkg::WGT_W'(n_ff);
      u_w = cbs_pkg::WGT_W'(u_val);
   end

   // largest magnitude of the vector being normalized
   always_comb begin
      nrm_max = mag_ff[0];
      if (mag_ff[1] > nrm_max) nrm_max = mag_ff[1];
      if (mag_ff[2] > nrm_max) nrm_max = mag_ff[2];
   end

   // accumulator picked for the position divide
   always_comb begin
      acc_sel = acc_ff[0][axis_ff];
      acc_abs = acc_sel[cbs_pkg::ACC_W-1] ? cbs_pkg::DVD_W'(-acc_sel)
                                          : cbs_pkg::DVD_W'(acc_sel);
   end

   // multiplier operand selection
   always_comb begin
      mult_a = '0;
      mult_b = '0;
      case (state_ff)
         cbs_pkg::ST_PREP_MUL: begin
            case (pidx_ff)
               4'd0: begin mult_a = cbs_pkg::MUL_A_W'(n_ff);     mult_b = cbs_pkg::MUL_B_W'(n_ff);     end
               4'd1: begin mult_a = cbs_pkg::MUL_A_W'(pr_ff[0]); mult_b = cbs_pkg::MUL_B_W'(n_ff);     end
               4'd2: begin mult_a = cbs_pkg::MUL_A_W'(s_ff);     mult_b = cbs_pkg::MUL_B_W'(s_ff);     end
               4'd3: begin mult_a = cbs_pkg::MUL_A_W'(pr_ff[2]); mult_b = cbs_pkg::MUL_B_W'(s_ff);     end
               4'd4: begin mult_a = cbs_pkg::MUL_A_W'(s_ff);     mult_b = cbs_pkg::MUL_B_W'(n_ff);     end
               4'd5: begin mult_a = cbs_pkg::MUL_A_W'(pr_ff[2]); mult_b = cbs_pkg::MUL_B_W'(n_ff);     end
               4'd6: begin mult_a = cbs_pkg::MUL_A_W'(s_ff);     mult_b = cbs_pkg::MUL_B_W'(pr_ff[0]); end
               4'd7: begin mult_a = cbs_pkg::MUL_A_W'(u_val);    mult_b = cbs_pkg::MUL_B_W'(u_val);    end
               default: begin
                  mult_a = cbs_pkg::MUL_A_W'(pr_ff[7]);
                  mult_b = cbs_pkg::MUL_B_W'(u_val);
               end
            endcase
         end
         cbs_pkg::ST_MAC_MUL: begin
            mult_a = wt_ff[fi_ff][ii_ff];
            mult_b = cbs_pkg::MUL_B_W'(pts[ii_ff][ji_ff]);
         end
         cbs_pkg::ST_SQ_MUL: begin
            mult_a = cbs_pkg::MUL_A_W'(mag_ff[axis_ff][cbs_pkg::NRM_HI-1:0]);
            mult_b = cbs_pkg::MUL_B_W'(mag_ff[axis_ff][cbs_pkg::NRM_HI-1:0]);
         end
         default: begin
            mult_a = '0;
            mult_b = '0;
         end
      endcase
   end

   assign prod_in = mult_a * mult_b;

   // divide / sqrt unit requests
   always_comb begin
      unit_req.start = 1'b0;
      unit_req.op    = cbs_pkg::UNIT_DIV;
      unit_a         = '0;
      unit_b         = '0;
      case (state_ff)
         cbs_pkg::ST_POS_START: begin
            unit_req.start = 1'b1;
            unit_a = acc_abs + cbs_pkg::DVD_W'(n3x3);
            unit_b = cbs_pkg::DVS_W'(n3x6);
         end
         cbs_pkg::ST_SQRT_START: begin
            unit_req.start = 1'b1;
            unit_req.op    = cbs_pkg::UNIT_SQRT;
            unit_a = cbs_pkg::DVD_W'(sum_ff[cbs_pkg::SQ_IN_W-1:0]);
         end
         cbs_pkg::ST_UDIV_START: begin
            unit_req.start = 1'b1;
            unit_a = cbs_pkg::DVD_W'({mag_ff[axis_ff][cbs_pkg::NRM_HI-1:0],
                                       cbs_pkg::UNIT_FRAC'(0)})
                     + cbs_pkg::DVD_W'(root_ff >> 1);
            unit_b = cbs_pkg::DVS_W'(root_ff);
         end
         default: begin
            unit_req.start = 1'b0;
         end
      endcase
   end

   cbs_divsqrt u_divsqrt (
      .clock     (clock),
      .reset     (reset),
      .unit_req  (unit_req),
      .operand_a (unit_a),
      .operand_b (unit_b),
      .unit_sts  (unit_sts),
      .result    (unit_result)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      scount_in     = csr_wr_en ? csr_wr_data : scount_ff;
      held_in       = held_ff;
      win_in        = win_ff;
      cur_in        = cur_ff;
      n_in          = n_ff;
      s_in          = s_ff;
      pidx_in       = pidx_ff;
      pr_in         = pr_ff;
      wt_in         = wt_ff;
      fi_in         = fi_ff;
      ji_in         = ji_ff;
      ii_in         = ii_ff;
      acc_in        = acc_ff;
      axis_in       = axis_ff;
      fam_in        = fam_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      sum_in        = sum_ff;
      root_in       = root_ff;
      pos_in        = pos_ff;
      uvec_in       = uvec_ff;
      deg_in        = deg_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tlast_in  = rsp_tlast_ff;

      case (state_ff)
         cbs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (held_eff != 2'd3) begin
                  for (int j = 0; j < 3; j++) win_in[held_eff][j] = in_pt[j];
                  held_in = held_eff + 2'd1;
               end else begin
                  cur_in   = in_pt;
                  n_in     = n_clamp;
                  s_in     = '0;
                  pidx_in  = '0;
                  state_in = cbs_pkg::ST_PREP_MUL;
               end
            end
         end
         cbs_pkg::ST_PREP_MUL: state_in = cbs_pkg::ST_PREP_ACC;
         cbs_pkg::ST_PREP_ACC: begin
            pr_in[pidx_ff] = prod_ff[cbs_pkg::PR_W-1:0];
            pidx_in = pidx_ff + 4'd1;
            state_in = (pidx_ff == 4'(cbs_pkg::NUM_PRODS-1)) ? cbs_pkg::ST_WGT
                                                             : cbs_pkg::ST_PREP_MUL;
         end
         cbs_pkg::ST_WGT: begin
            wt_in[0][0] = q[8];
            wt_in[0][1] = cbs_pkg::WGT_W'(3*q[3] - 6*q[5] + 4*q[1]);
            wt_in[0][2] = cbs_pkg::WGT_W'(3*q[5] + 3*q[6] + q[1] - 3*q[3]);
            wt_in[0][3] = q[3];
            wt_in[1][0] = cbs_pkg::WGT_W'(-3*q[7]);
            wt_in[1][1] = cbs_pkg::WGT_W'(9*q[2] - 12*q[4]);
            wt_in[1][2] = cbs_pkg::WGT_W'(6*q[4] + 3*q[0] - 9*q[2]);
            wt_in[1][3] = cbs_pkg::WGT_W'(3*q[2]);
            wt_in[2][0] = u_w;
            wt_in[2][1] = cbs_pkg::WGT_W'(3*s_w - 2*n_w);
            wt_in[2][2] = cbs_pkg::WGT_W'(n_w - 3*s_w);
            wt_in[2][3] = s_w;
            for (int f = 0; f < 3; f++)
               for (int j = 0; j < 3; j++) acc_in[f][j] = '0;
            deg_in   = 1'b0;
            fi_in    = '0;
            ji_in    = '0;
            ii_in    = '0;
            state_in = cbs_pkg::ST_MAC_MUL;
         end
         cbs_pkg::ST_MAC_MUL: state_in = cbs_pkg::ST_MAC_ACC;
         cbs_pkg::ST_MAC_ACC: begin
            acc_in[fi_ff][ji_ff] = acc_ff[fi_ff][ji_ff] + prod_ff;
            state_in = cbs_pkg::ST_MAC_MUL;
            ii_in = ii_ff + 2'd1;
            if (ii_ff == 2'd3) begin
               ji_in = ji_ff + 2'd1;
               if (ji_ff == 2'd2) begin
                  ji_in = '0;
                  fi_in = fi_ff + 2'd1;
                  if (fi_ff == 2'd2) begin
                     axis_in  = '0;
                     state_in = cbs_pkg::ST_POS_START;
                  end
               end
            end
         end
         cbs_pkg::ST_POS_START: state_in = cbs_pkg::ST_POS_WAIT;
         cbs_pkg::ST_POS_WAIT: begin
            if (unit_sts.done) begin
               // round to nearest, then saturate to the coordinate range
               if (!acc_sel[cbs_pkg::ACC_W-1])
                  pos_in[axis_ff] = (unit_result > SAT_POS) ? POS_MAX : unit_result[CW-1:0];
               else
                  pos_in[axis_ff] = (unit_result > SAT_MAG) ? NEG_MIN
                                                            : CW'(-unit_result[CW-1:0]);
               axis_in = axis_ff + 2'd1;
               if (axis_ff == 2'd2) begin
                  axis_in  = '0;
                  fam_in   = 1'b0;
                  state_in = cbs_pkg::ST_VEC_LOAD;
               end else begin
                  state_in = cbs_pkg::ST_POS_START;
               end
            end
         end
         cbs_pkg::ST_VEC_LOAD: begin
            for (int k = 0; k < 3; k++) begin
               neg_in[k] = acc_ff[fam_ff ? 2 : 1][k][cbs_pkg::ACC_W-1];
               mag_in[k] = neg_in[k] ? cbs_pkg::DVD_W'(-acc_ff[fam_ff ? 2 : 1][k])
                                     : cbs_pkg::DVD_W'(acc_ff[fam_ff ? 2 : 1][k]);
            end
            if (mag_in[0] == '0 && mag_in[1] == '0 && mag_in[2] == '0) begin
               // zero-length derivative: zero vector and flag
               deg_in = 1'b1;
               for (int k = 0; k < 3; k++) uvec_in[fam_ff][k] = '0;
               if (!fam_ff) begin
                  fam_in   = 1'b1;
                  state_in = cbs_pkg::ST_VEC_LOAD;
               end else begin
                  state_in = cbs_pkg::ST_EMIT;
               end
            end else begin
               state_in = cbs_pkg::ST_VEC_NORM;
            end
         end
         cbs_pkg::ST_VEC_NORM: begin
            if (nrm_max[cbs_pkg::DVD_W-1:cbs_pkg::NRM_HI] != '0) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] >> 1;
            end else if (!nrm_max[cbs_pkg::NRM_LO]) begin
               for (int k = 0; k < 3; k++) mag_in[k] = mag_ff[k] << 1;
            end else begin
               axis_in  = '0;
               sum_in   = '0;
               state_in = cbs_pkg::ST_SQ_MUL;
            end
         end
         cbs_pkg::ST_SQ_MUL: state_in = cbs_pkg::ST_SQ_ACC;
         cbs_pkg::ST_SQ_ACC: begin
            sum_in  = sum_ff + cbs_pkg::PROD_W'(prod_ff);
            axis_in = axis_ff + 2'd1;
            state_in = (axis_ff == 2'd2) ? cbs_pkg::ST_SQRT_START : cbs_pkg::ST_SQ_MUL;
         end
         cbs_pkg::ST_SQRT_START: begin
            axis_in  = '0;
            state_in = cbs_pkg::ST_SQRT_WAIT;
         end
         cbs_pkg::ST_SQRT_WAIT: begin
            if (unit_sts.done) begin
               root_in  = unit_result[cbs_pkg::ROOT_W-1:0];
               state_in = cbs_pkg::ST_UDIV_START;
            end
         end
         cbs_pkg::ST_UDIV_START: state_in = cbs_pkg::ST_UDIV_WAIT;
         cbs_pkg::ST_UDIV_WAIT: begin
            if (unit_sts.done) begin
               uvec_in[fam_ff][axis_ff] = neg_ff[axis_ff]
                  ? cbs_pkg::UNIT_W'(-unit_result[cbs_pkg::UNIT_W-1:0])
                  : unit_result[cbs_pkg::UNIT_W-1:0];
               axis_in = axis_ff + 2'd1;
               if (axis_ff == 2'd2) begin
                  axis_in = '0;
                  if (!fam_ff) begin
                     fam_in   = 1'b1;
                     state_in = cbs_pkg::ST_VEC_LOAD;
                  end else begin
                     state_in = cbs_pkg::ST_EMIT;
                  end
               end else begin
                  state_in = cbs_pkg::ST_UDIV_START;
               end
            end
         end
         cbs_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = OUT_W'({uvec_ff[1][2], uvec_ff[1][1], uvec_ff[1][0],
                                       uvec_ff[0][2], uvec_ff[0][1], uvec_ff[0][0],
                                       pos_ff[2], pos_ff[1], pos_ff[0]});
               rsp_tuser_in  = deg_ff;
               rsp_tlast_in  = is_last;
               if (is_last) begin
                  // slide the window by one point
                  win_in[0] = win_ff[1];
                  win_in[1] = win_ff[2];
                  win_in[2] = cur_ff;
                  state_in  = cbs_pkg::ST_IDLE;
               end else begin
                  s_in     = s_ff + cbs_pkg::CNT_W'(1);
                  pidx_in  = '0;
                  state_in = cbs_pkg::ST_PREP_MUL;
               end
            end
         end
         default: state_in = cbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= cbs_pkg::ST_IDLE;
         scount_ff     <= cbs_pkg::SCOUNT_RESET;
         held_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scount_ff     <= scount_in;
         held_ff       <= held_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      win_ff       <= win_in;
      cur_ff       <= cur_in;
      n_ff         <= n_in;
      s_ff         <= s_in;
      pidx_ff      <= pidx_in;
      pr_ff        <= pr_in;
      wt_ff        <= wt_in;
      fi_ff        <= fi_in;
      ji_ff        <= ji_in;
      ii_ff        <= ii_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      axis_ff      <= axis_in;
      fam_ff       <= fam_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      sum_ff       <= sum_in;
      root_ff      <= root_in;
      pos_ff       <= pos_in;
      uvec_ff      <= uvec_in;
      deg_ff       <= deg_in;
      rsp_tdata_ff <= rsp_tdata_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tlast_ff <= rsp_tlast_in;
   end

   assign req_tready = (state_ff == cbs_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // squares start only on a vector normalized into [2^23, 2^24)
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbs_pkg::ST_SQ_MUL && axis_ff == 2'd0) |->
      (nrm_max[cbs_pkg::DVD_W-1:cbs_pkg::NRM_HI] == '0 && nrm_max[cbs_pkg::NRM_LO]))
      else $error("square stage entered with unnormalized vector");

   // the shared unit only finishes while the sequencer waits for it
   a_unit_done: assert property (@(posedge clock) disable iff (reset)
      unit_sts.done |-> (state_ff == cbs_pkg::ST_POS_WAIT ||
                         state_ff == cbs_pkg::ST_SQRT_WAIT ||
                         state_ff == cbs_pkg::ST_UDIV_WAIT))
      else $error("divide/sqrt result arrived outside a wait state");

   // root of a normalized sum of squares lies in [2^23, 2^25)
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbs_pkg::ST_SQRT_WAIT && unit_sts.done) |->
      (unit_result[cbs_pkg::DVD_W-1:cbs_pkg::ROOT_W] == '0 &&
       unit_result[cbs_pkg::ROOT_W-1:cbs_pkg::NRM_LO] != '0))
      else $error("square root out of range");

   // the final sample of a segment returns the block to idle, marked last
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cbs_pkg::ST_EMIT && out_free && is_last) |=>
      (state_ff == cbs_pkg::ST_IDLE && rsp_tvalid && rsp_tlast))
      else $error("segment end did not return to idle");

endmodule

FILE: sim/cbs_checker.sv
// Checker for the cubic B-spline sampler: watches the channels, predicts samples, compares.
module cbs_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic         req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [143:0] rsp_tdata,
   input  logic         rsp_tuser,
   input  logic         rsp_tlast,
   output int           errors,
   output int           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [143:0] vec;
      logic         degenerate;
      logic         last_sample;
   } sample_type;

   sample_type  sample_q[$];
   longint      window[3][3];
   int          held;
   logic [6:0]  seg_samples;

   string field_name[9] = '{"pos_x", "pos_y", "pos_z", "tan_x", "tan_y", "tan_z",
                            "curv_x", "curv_y", "curv_z"};

   task automatic report(input string what, input longint got, input longint want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   // floor of the square root, one result bit at a time
   function automatic longint unsigned root_floor(input longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int b = 26; b >= 0; b--) begin
         t = r | (64'd1 << b);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   // Q1.14 unit vector of an exact derivative; zero flags a null vector
   function automatic logic [47:0] unit_dir(input longint v0, v1, v2, output bit zero);
      longint unsigned mag[3], top, sum, r, q;
      longint          v[3];
      logic [47:0]     res;
      v = '{v0, v1, v2};
      top = 0;
      res = '0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = (v[k] < 0) ? -v[k] : v[k];
         if (mag[k] > top) top = mag[k];
      end
      zero = (top == 0);
      if (zero) return res;
      while (top >= (64'd1 << 24)) begin
         top >>= 1;
         for (int k = 0; k < 3; k++) mag[k] >>= 1;
      end
      while (top < (64'd1 << 23)) begin
         top <<= 1;
         for (int k = 0; k < 3; k++) mag[k] <<= 1;
      end
      sum = 0;
      for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
      r = root_floor(sum);
      for (int k = 0; k < 3; k++) begin
         q = (mag[k] * 16384 + r / 2) / r;
         if (v[k] < 0) q = -q;
         res[16*k +: 16] = q[15:0];
      end
      return res;
   endfunction

   // all samples of the segment closed by point p3
   task automatic predict_segment(input longint p3[3]);
      longint  p[4][3], w[4], d[4], e[4], dv[3], ev[3];
      longint  n, u, n3, num, pos;
      longint unsigned mag;
      bit      z1, z2;
      sample_type smp;
      n = seg_samples;
      if (n < 1) n = 1;
      if (n > 64) n = 64;
      n3 = 6 * n * n * n;
      for (int i = 0; i < 3; i++) p[i] = window[i];
      p[3] = p3;
      for (longint s = 0; s < n; s++) begin
         u = n - s;
         w = '{u*u*u, 3*s*s*s - 6*s*s*n + 4*n*n*n,
               -3*s*s*s + 3*s*s*n + 3*s*n*n + n*n*n, s*s*s};
         d = '{-3*u*u, 9*s*s - 12*s*n, -9*s*s + 6*s*n + 3*n*n, 3*s*s};
         e = '{u, 3*s - 2*n, n - 3*s, s};
         for (int j = 0; j < 3; j++) begin
            num = 0;
            dv[j] = 0;
            ev[j] = 0;
            for (int i = 0; i < 4; i++) begin
               num   += w[i] * p[i][j];
               dv[j] += d[i] * p[i][j];
               ev[j] += e[i] * p[i][j];
            end
            mag = (num < 0) ? -num : num;
            mag = (mag + n3 / 2) / n3;
            pos = (num < 0) ? -longint'(mag) : longint'(mag);
            if (pos > 32767) pos = 32767;
            if (pos < -32768) pos = -32768;
            smp.vec[16*j +: 16] = pos[15:0];
         end
         smp.vec[48 +: 48] = unit_dir(dv[0], dv[1], dv[2], z1);
         smp.vec[96 +: 48] = unit_dir(ev[0], ev[1], ev[2], z2);
         smp.degenerate  = z1 | z2;
         smp.last_sample = (s == n - 1);
         sample_q = {sample_q, smp};
      end
      window[0] = p[1];
      window[1] = p[2];
      window[2] = p3;
   endtask

   always @(posedge clock) begin
      longint     pt[3];
      sample_type want;
      if (reset) begin
         held = 0;
         errors = 0;
         seg_samples = 7'd8;
         sample_q.delete();
      end else begin
         if (csr_wr_en) seg_samples = csr_wr_data;
         // input transaction: store point or close a segment
         if (req_tvalid && req_tready) begin
            for (int j = 0; j < 3; j++) pt[j] = $signed(req_tdata[16*j +: 16]);
            if (req_tuser) held = 0;
            if (held < 3) begin
               window[held] = pt;
               held++;
            end else begin
               predict_segment(pt);
            end
         end
         // result transaction against the oldest expected sample
         if (rsp_tvalid && rsp_tready) begin
            if (sample_q.size() == 0) begin
               report("unexpected transaction", 0, 0);
            end else begin
               want = sample_q.pop_front();
               for (int k = 0; k < 9; k++)
                  if (rsp_tdata[16*k +: 16] !== want.vec[16*k +: 16])
                     report(field_name[k], $signed(rsp_tdata[16*k +: 16]),
                            $signed(want.vec[16*k +: 16]));
               if (rsp_tuser !== want.degenerate)
                  report("degenerate", longint'(rsp_tuser), longint'(want.degenerate));
               if (rsp_tlast !== want.last_sample)
                  report("last_sample", longint'(rsp_tlast), longint'(want.last_sample));
            end
         end
      end
      pending = sample_q.size();
   end
endmodule

FILE: sim/cubic_bspline_sampler_tb.sv
// Testbench top for the cubic B-spline sampler: stimulus, clock, reset and verdict.
module cubic_bspline_sampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 40000000;

   logic         clock = 0;
   logic         reset = 1;
   logic         csr_wr_en = 0;
   logic [6:0]   csr_wr_data = '0;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [47:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser;
   logic         rsp_tlast;
   int           errors, pending;
   int           cycles = 0;
   bit           no_gaps = 0;
   logic [15:0]  last_pt[3] = '{16'd0, 16'd0, 16'd0};

   always #4 clock = ~clock;

   cubic_bspline_sampler dut (.*);

   cbs_checker u_checker (.*);

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("cubic_bspline_sampler_tb NOT OK");
         $finish;
      end
   end

   // mostly short gaps, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(60, 10);
   endfunction

   // result side backpressure
   initial begin
      int g;
      @(negedge reset);
      forever begin
         rsp_tready <= 1;
         repeat ($urandom_range(40, 1)) @(posedge clock);
         g = gap_len();
         if (g > 0) begin
            rsp_tready <= 0;
            repeat (g) @(posedge clock);
         end
      end
   end

   // one point transaction; ready is sampled mid-cycle, stable up to the edge
   task automatic send_point(input logic [15:0] x, y, z, input logic start);
      int g;
      req_tvalid <= 1;
      req_tdata  <= {z, y, x};
      req_tuser  <= start;
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      last_pt = '{x, y, z};
      g = no_gaps ? 0 : gap_len();
      if (g > 0) begin
         req_tvalid <= 0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic set_samples(input logic [6:0] n);
      wait_drained();
      repeat (20) @(posedge clock);
      csr_wr_en   <= 1;
      csr_wr_data <= n;
      @(posedge clock);
      csr_wr_en <= 0;
      @(posedge clock);
   endtask

   // random point: mostly a smooth walk, some full-range noise, some repeats
   task automatic send_random(input logic start);
      logic [15:0] c[3];
      int          r, v;
      r = $urandom_range(99);
      for (int k = 0; k < 3; k++) begin
         if (r < 70) begin
            v = $signed(last_pt[k]) + $signed($urandom_range(4000)) - 2000;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            c[k] = v[15:0];
         end else if (r < 90) begin
            c[k] = 16'($urandom());
         end else begin
            c[k] = last_pt[k];
         end
      end
      send_point(c[0], c[1], c[2], start);
   endtask

   initial begin
      logic [6:0] plan[12] = '{7'd2, 7'd1, 7'd3, 7'd0, 7'd4, 7'd64,
                               7'd2, 7'd127, 7'd1, 7'd5, 7'd8, 7'd3};
      int items;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: all-equal points at the reset sample count give null derivatives
      send_point(16'h0000, 16'h0000, 16'h0000, 1);
      repeat (3) send_point(16'h0000, 16'h0000, 16'h0000, 0);

      // directed at one sample per segment
      set_samples(7'd1);
      send_point(16'h8000, 16'h8000, 16'h8000, 1);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_point(16'h8000, 16'h8000, 16'h8000, 0);
      send_point(16'h7fff, 16'h7fff, 16'h7fff, 0);
      send_point(16'h8000, 16'h7fff, 16'h8000, 0);
      send_point(16'h7fff, 16'h8000, 16'h0000, 0);
      // evenly spaced line: zero second derivative
      send_point(16'd0, 16'd0, 16'd0, 1);
      send_point(16'd256, 16'd256, 16'd256, 0);
      send_point(16'd512, 16'd512, 16'd512, 0);
      send_point(16'd768, 16'd768, 16'd768, 0);
      // one-LSB steps exercise the left normalization shift
      send_point(16'd1, 16'hffff, 16'd0, 0);
      send_point(16'd0, 16'd1, 16'hffff, 0);
      // restart with fewer than three points held
      send_point(16'd100, 16'd200, 16'd300, 1);
      send_point(16'd50, 16'd10, 16'd5, 1);
      send_point(16'h1234, 16'h5678, 16'h9abc, 0);
      send_point(16'hffff, 16'h0001, 16'h4000, 0);
      send_point(16'h0100, 16'hfe00, 16'h0200, 0);

      // random phases over several sample counts
      for (int ph = 0; ph < 12; ph++) begin
         set_samples(plan[ph]);
         no_gaps = (ph % 4 == 2);
         items = (plan[ph] >= 64) ? 2 : 15;
         for (int i = 0; i < items; i++) begin
            if (ph == 4 && i == 7) wait_drained();
            send_random(items > 2 && $urandom_range(9) == 0);
         end
      end

      wait_drained();
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("cubic_bspline_sampler_tb OK");
      else
         $display("cubic_bspline_sampler_tb NOT OK");
      $finish;
   end
endmodule

FILE: files.f
hw/rtl/cbs_pkg.sv
hw/rtl/cbs_divsqrt.sv
hw/rtl/cubic_bspline_sampler.sv
sim/cbs_checker.sv
sim/cubic_bspline_sampler_tb.sv
